FILE: rtl/signed_int_to_decimal_ascii_assert.svh
// assertion macros for the signed integer to decimal text block
// used by the checker module; needs clk and rst in the scope of use
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sida_pkg.sv
// shared constants, types and state codes for the decimal text block
// no dependencies
`default_nettype none

package sida_pkg;

  // width of the integer and derived digit storage
  localparam int VALUE_WIDTH = 64;
  localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W       = DIGITS * 4;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(DIGITS + 1);
  localparam int TEXT_W      = 8;

  // character codes
  localparam logic [TEXT_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [TEXT_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [TEXT_W-1:0] CHAR_NINE  = 8'h39;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } sida_state_t;

  // commands from the sequencer to the conversion unit
  typedef struct packed {
    logic load;
    logic step;
    logic dshift;
  } sida_cmd_t;

  // status from the conversion unit to the sequencer
  typedef struct packed {
    logic [3:0] top;
    logic       neg;
  } sida_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sida_dabble.sv
// shift-and-add-3 conversion unit: magnitude shift register and bcd digit register
// depends on sida_pkg
`default_nettype none

module sida_dabble
  import sida_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire sida_cmd_t              cmd,
  output sida_stat_t                  stat
);

  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] mag_next;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_next;
  logic [BCD_W-1:0]       bcd_adj;
  logic                   neg;
  logic                   neg_next;
  logic [VALUE_WIDTH-1:0] raw;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // load, dabble step or digit shift
  always_comb begin
    raw      = value;
    mag_next = mag;
    bcd_next = bcd;
    neg_next = neg;
    if (cmd.load) begin
      neg_next = raw[VALUE_WIDTH-1];
      mag_next = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
      bcd_next = '0;
    end else if (cmd.step) begin
      bcd_next = {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
      mag_next = {mag[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.dshift) begin
      bcd_next = {bcd[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
    bcd <= bcd_next;
    neg <= neg_next;
  end

  assign stat.top = bcd[BCD_W-1 -: 4];
  assign stat.neg = neg;

endmodule

`default_nettype wire

FILE: rtl/sida_ctrl.sv
// sequencer and output register: runs the conversion, skips leading zeros,
// emits sign and digit beats; depends on sida_pkg
`default_nettype none

module sida_ctrl
  import sida_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [TEXT_W-1:0]      text_byte,
  output logic                   last_byte,
  output sida_cmd_t              cmd,
  input  wire sida_stat_t        stat
);

  sida_state_t          state;
  sida_state_t          state_next;
  logic [BIT_CNT_W-1:0] bitcnt;
  logic [BIT_CNT_W-1:0] bitcnt_next;
  logic [DIG_CNT_W-1:0] dcnt;
  logic [DIG_CNT_W-1:0] dcnt_next;
  logic                 sign_pend;
  logic                 sign_pend_next;
  logic                 out_valid_next;
  logic [TEXT_W-1:0]    text_byte_next;
  logic                 last_byte_next;
  logic                 slot_free;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // counters and payload
  always_ff @(posedge clk) begin
    bitcnt    <= bitcnt_next;
    dcnt      <= dcnt_next;
    sign_pend <= sign_pend_next;
    text_byte <= text_byte_next;
    last_byte <= last_byte_next;
  end

  assign slot_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next     = state;
    bitcnt_next    = bitcnt;
    dcnt_next      = dcnt;
    sign_pend_next = sign_pend;
    out_valid_next = out_valid && out_stall;
    text_byte_next = text_byte;
    last_byte_next = last_byte;
    cmd            = '0;
    in_stall       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          bitcnt_next = BIT_CNT_W'(VALUE_WIDTH - 1);
          dcnt_next   = DIG_CNT_W'(DIGITS);
          state_next  = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (bitcnt == '0) begin
          state_next = ST_SKIP;
        end else begin
          bitcnt_next = bitcnt - 1'b1;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (stat.top == 4'd0 && dcnt > DIG_CNT_W'(1)) begin
          cmd.dshift = 1'b1;
          dcnt_next  = dcnt - 1'b1;
        end else begin
          sign_pend_next = stat.neg;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          if (sign_pend) begin
            text_byte_next = CHAR_MINUS;
            last_byte_next = 1'b0;
            sign_pend_next = 1'b0;
          end else begin
            text_byte_next = CHAR_ZERO + TEXT_W'(stat.top);
            last_byte_next = (dcnt == DIG_CNT_W'(1));
            cmd.dshift     = 1'b1;
            dcnt_next      = dcnt - 1'b1;
            if (dcnt == DIG_CNT_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text, top level.
// Input channel: value with in_valid / in_stall. One beat carries one signed
// integer; only its low VALUE_WIDTH bits are used.
// Output channel: text_byte and last_byte with out_valid / out_stall. Each
// beat is one character, most significant first: an optional '-', then the
// digits with leading zeros dropped; last_byte marks the final beat. Zero
// gives the single beat '0'. The most negative value is rendered exactly.
// Sequence: a load, then VALUE_WIDTH shift-and-add-3 steps, each adjusting
// every digit position in parallel, then a skip of the leading zero digits,
// then the characters in order. Skipped and sent digits always cover all
// 20 digit positions; at 64 bits, 1 to 19 leading zero digits are dropped.
// A negative value sends one more beat, the sign.
// in_stall is high from the accepted beat until the last character is
// loaded, so the next item may start while that character waits. When the
// receiver stalls, the output register holds its character and the
// sequencer waits. Reset (rst, synchronous) clears the sequencer and the
// output valid; nothing else is kept. Depends on sida_pkg, sida_dabble, sida_ctrl.
`default_nettype none

module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [63:0]       value,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic [TEXT_W-1:0]      text_byte,
  output logic                   last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall
);

  sida_cmd_t  cmd;
  sida_stat_t stat;

  // shared conversion unit
  sida_dabble u_dabble (
    .clk   (clk),
    .value (value[VALUE_WIDTH-1:0]),
    .cmd   (cmd),
    .stat  (stat)
  );

  // sequencer and output register
  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

FILE: rtl/sida_check.sv
// port-level checker for the decimal text block, bound to the top level
// depends on sida_pkg and signed_int_to_decimal_ascii_assert.svh
`default_nettype none
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_check
  import sida_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [TEXT_W-1:0] text_byte,
  input wire logic              last_byte,
  input wire logic              out_valid,
  input wire logic              out_stall
);

  // a stalled output beat holds
  `SIDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(text_byte) && $stable(last_byte), "stalled output beat changed")

  // only a sign or a digit is ever sent
  `SIDA_ASSERT_NOW(a_char_set, out_valid, text_byte == CHAR_MINUS || (text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE), "bad character")

  // a sign is always followed by digits
  `SIDA_ASSERT_NOW(a_sign_not_last, out_valid && text_byte == CHAR_MINUS, !last_byte, "sign marked last")

  // an accepted item busies the input side
  `SIDA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled during conversion")

endmodule

bind signed_int_to_decimal_ascii sida_check u_check (.*);

`default_nettype wire
